### hdl/hfp_pkg.sv
// shared types, constants and tangent threshold table for the heading pipeline
package hfp_pkg;

    localparam int unsigned CoordW  = 32;
    localparam int unsigned IdxW    = 6;
    localparam int unsigned ThrW    = 14;
    localparam int unsigned HeadW   = 8;
    localparam int unsigned SearchN = 6;

    localparam logic [HeadW-1:0] HeadUp    = 8'd0;
    localparam logic [HeadW-1:0] HeadRight = 8'd64;
    localparam logic [HeadW-1:0] HeadDown  = 8'd128;
    localparam logic [HeadW-1:0] HeadLeft  = 8'd192;

    // payload carried from the front end through the search stages
    typedef struct packed {
        logic              dx_zero;
        logic              down;
        logic              den_neg;
        logic              neg;
        logic [CoordW-1:0] num;
        logic [CoordW-1:0] den;
        logic [IdxW-1:0]   cnt;
    } hfp_stage_t;

    // tangent threshold plus one; the last entry never takes part in the search
    function automatic logic [ThrW-1:0] tan_plus1(input logic [IdxW-1:0] idx);
        logic [ThrW-1:0] t;
        case (idx)
            6'd0:  t = 14'd8;
            6'd1:  t = 14'd14;
            6'd2:  t = 14'd20;
            6'd3:  t = 14'd27;
            6'd4:  t = 14'd33;
            6'd5:  t = 14'd39;
            6'd6:  t = 14'd46;
            6'd7:  t = 14'd52;
            6'd8:  t = 14'd59;
            6'd9:  t = 14'd66;
            6'd10: t = 14'd72;
            6'd11: t = 14'd79;
            6'd12: t = 14'd86;
            6'd13: t = 14'd93;
            6'd14: t = 14'd100;
            6'd15: t = 14'd108;
            6'd16: t = 14'd115;
            6'd17: t = 14'd123;
            6'd18: t = 14'd130;
            6'd19: t = 14'd138;
            6'd20: t = 14'd147;
            6'd21: t = 14'd155;
            6'd22: t = 14'd164;
            6'd23: t = 14'd173;
            6'd24: t = 14'd182;
            6'd25: t = 14'd191;
            6'd26: t = 14'd201;
            6'd27: t = 14'd212;
            6'd28: t = 14'd222;
            6'd29: t = 14'd234;
            6'd30: t = 14'd245;
            6'd31: t = 14'd257;
            6'd32: t = 14'd270;
            6'd33: t = 14'd284;
            6'd34: t = 14'd298;
            6'd35: t = 14'd313;
            6'd36: t = 14'd330;
            6'd37: t = 14'd347;
            6'd38: t = 14'd365;
            6'd39: t = 14'd385;
            6'd40: t = 14'd406;
            6'd41: t = 14'd429;
            6'd42: t = 14'd453;
            6'd43: t = 14'd480;
            6'd44: t = 14'd510;
            6'd45: t = 14'd543;
            6'd46: t = 14'd579;
            6'd47: t = 14'd620;
            6'd48: t = 14'd665;
            6'd49: t = 14'd717;
            6'd50: t = 14'd776;
            6'd51: t = 14'd845;
            6'd52: t = 14'd927;
            6'd53: t = 14'd1024;
            6'd54: t = 14'd1142;
            6'd55: t = 14'd1288;
            6'd56: t = 14'd1477;
            6'd57: t = 14'd1727;
            6'd58: t = 14'd2077;
            6'd59: t = 14'd2601;
            6'd60: t = 14'd3472;
            6'd61: t = 14'd5212;
            6'd62: t = 14'd10430;
            default: t = '1;
        endcase
        return t;
    endfunction

endpackage

### hdl/hfp_front.sv
// front end: coordinate deltas, then magnitudes, signs and special-case flags
module hfp_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       en_a,
    input  logic                       en_b,
    input  logic [hfp_pkg::CoordW-1:0] source_x,
    input  logic [hfp_pkg::CoordW-1:0] source_y,
    input  logic [hfp_pkg::CoordW-1:0] target_x,
    input  logic [hfp_pkg::CoordW-1:0] target_y,
    output logic                       valid_a,
    output logic                       valid_b,
    output hfp_pkg::hfp_stage_t        stage_b
);
    import hfp_pkg::*;

    logic              valid_a_reg;
    logic              valid_b_reg;
    logic [CoordW-1:0] dx_reg;
    logic [CoordW-1:0] dy_reg;
    hfp_stage_t        stage_b_reg;
    hfp_stage_t        stage_b_next;

    logic [CoordW-1:0] num;
    logic [CoordW-1:0] num_mag;
    logic [CoordW-1:0] den_mag;
    logic              num_neg;
    logic              den_neg;
    logic              q_nonzero;
    logic              q_max;

    always_comb
    begin
        num      = {dy_reg[CoordW-9:0], 8'b0};
        num_neg  = num[CoordW-1];
        den_neg  = dx_reg[CoordW-1];
        num_mag  = num_neg ? (~num + 1'b1) : num;
        den_mag  = den_neg ? (~dx_reg + 1'b1) : dx_reg;
        q_nonzero = num_mag >= den_mag;
        // a quotient of 2^31 wraps negative
        q_max    = (num_mag == {1'b1, {(CoordW-1){1'b0}}}) &&
                   (den_mag == {{(CoordW-1){1'b0}}, 1'b1});

        stage_b_next.dx_zero = (dx_reg == '0);
        stage_b_next.down    = !dy_reg[CoordW-1] && (dy_reg != '0);
        stage_b_next.den_neg = den_neg;
        stage_b_next.neg     = (q_nonzero && (num_neg != den_neg)) || q_max;
        stage_b_next.num     = num_mag;
        stage_b_next.den     = den_mag;
        stage_b_next.cnt     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                valid_a_reg <= in_valid;
            end
            if (en_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            dx_reg <= target_x - source_x;
            dy_reg <= target_y - source_y;
        end
        if (en_b)
        begin
            stage_b_reg <= stage_b_next;
        end
    end

    assign valid_a = valid_a_reg;
    assign valid_b = valid_b_reg;
    assign stage_b = stage_b_reg;

endmodule

### hdl/hfp_search.sv
// one binary search step over the tangent thresholds: multiply and compare
module hfp_search (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic [2:0]          step,
    input  logic                valid_in,
    input  hfp_pkg::hfp_stage_t stage_in,
    output logic                valid_out,
    output hfp_pkg::hfp_stage_t stage_out
);
    import hfp_pkg::*;

    logic                   valid_reg;
    hfp_stage_t             stage_reg;
    hfp_stage_t             stage_next;
    logic [IdxW-1:0]        cand;
    logic [ThrW-1:0]        thr;
    logic [CoordW+ThrW-1:0] prod;
    logic                   hit;

    always_comb
    begin
        cand = stage_in.cnt | (IdxW'(1) << step);
        thr  = tan_plus1(cand - 1'b1);
        prod = stage_in.den * thr;
        // quotient exceeds threshold exactly when num >= (t + 1) * den
        hit  = {{ThrW{1'b0}}, stage_in.num} >= prod;
        stage_next     = stage_in;
        stage_next.cnt = hit ? cand : stage_in.cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;

endmodule

### hdl/heading_from_points.sv
// top level: heading from a source point to a target point, fully pipelined
// Takes one point pair per clock unless in_stall is high. Each transaction
// passes through two front-end stages (deltas, then magnitudes and signs),
// six binary search stages over the 63 tangent thresholds, each one 32x14
// multiply and compare, and an output register. Every stage holds its
// transaction under stall and moves on as soon as the next stage has room, so a
// stall on the output side only backs up the stages that are full.
module heading_from_points (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [hfp_pkg::CoordW-1:0] source_x,
    input  logic [hfp_pkg::CoordW-1:0] source_y,
    input  logic [hfp_pkg::CoordW-1:0] target_x,
    input  logic [hfp_pkg::CoordW-1:0] target_y,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [hfp_pkg::HeadW-1:0]  heading
);
    import hfp_pkg::*;

    logic                  valid_a;
    logic                  en_a;
    logic                  en_b;
    logic [SearchN:0]      sv;
    hfp_stage_t            ss [SearchN+1];
    logic [SearchN:0]      sen;
    logic                  en_out;
    logic                  out_valid_reg;
    logic [HeadW-1:0]      heading_reg;
    logic [HeadW-1:0]      heading_next;
    logic [HeadW-1:0]      base;
    logic [HeadW-1:0]      offs;

    hfp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .en_a     (en_a),
        .en_b     (en_b),
        .source_x (source_x),
        .source_y (source_y),
        .target_x (target_x),
        .target_y (target_y),
        .valid_a  (valid_a),
        .valid_b  (sv[0]),
        .stage_b  (ss[0])
    );

    for (genvar g = 0; g < SearchN; g++)
    begin : g_search
        hfp_search u_search (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (sen[g+1]),
            .step      (3'(SearchN - 1 - g)),
            .valid_in  (sv[g]),
            .stage_in  (ss[g]),
            .valid_out (sv[g+1]),
            .stage_out (ss[g+1])
        );
    end

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        en_out = !out_valid_reg || !out_stall;
        sen[SearchN] = !sv[SearchN] || en_out;
        for (int k = SearchN - 1; k >= 0; k--)
        begin
            sen[k] = !sv[k] || sen[k+1];
        end
        en_b = sen[0];
        en_a = !valid_a || en_b;
    end

    assign in_stall = !en_a;

    always_comb
    begin
        base = ss[SearchN].den_neg ? HeadLeft : HeadRight;
        offs = {{(HeadW-IdxW){1'b0}}, ss[SearchN].cnt};
        if (ss[SearchN].dx_zero)
        begin
            heading_next = ss[SearchN].down ? HeadDown : HeadUp;
        end
        else if (ss[SearchN].neg)
        begin
            heading_next = base - offs;
        end
        else
        begin
            heading_next = base + offs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en_out)
        begin
            out_valid_reg <= sv[SearchN];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            heading_reg <= heading_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign heading   = heading_reg;

endmodule
